[src/ctr_pkg.sv]
// Shared types and constants for the coalescing trace ring.
package ctr_pkg;

  // Request codes carried in the opcode field
  localparam logic [1:0] OP_DISPATCH = 2'd0;
  localparam logic [1:0] OP_ARRIVAL  = 2'd1;
  localparam logic [1:0] OP_EMIT     = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  // Record kinds as stored and reported
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_ARRIVAL  = 2'd2;
  localparam logic [1:0] KIND_EMIT     = 2'd3;

  // Event code forced into emit records
  localparam logic [7:0] NO_EVENT_CODE = 8'd255;

  // Slot field width in a command, wide enough for the largest ring
  localparam int MAX_SLOT_W = 12;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        time_ms;
    logic [7:0]         fsm_state;
    logic [7:0]         event_code;
    logic [7:0]         detail_code;
    logic [7:0]         sub_a;
    logic [7:0]         sub_b;
    logic signed [31:0] return_code;
    logic [31:0]        aux_value;
    logic [5:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         entry_kind;
    logic [7:0]         entry_state;
    logic [7:0]         entry_event;
    logic [7:0]         entry_detail;
    logic [7:0]         entry_sub_a;
    logic [7:0]         entry_sub_b;
    logic signed [31:0] entry_rc;
    logic [31:0]        entry_aux;
    logic [31:0]        first_time;
    logic [31:0]        last_time;
    logic [31:0]        sequence_res;
    logic [31:0]        repeat_count;
  } out_item_t;

  // One ring slot
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         fsm_state;
    logic [7:0]         event_code;
    logic [7:0]         detail_code;
    logic [7:0]         sub_a;
    logic [7:0]         sub_b;
    logic signed [31:0] rc;
    logic [31:0]        aux;
    logic [31:0]        first_time;
    logic [31:0]        last_time;
    logic [31:0]        repeats;
  } entry_t;

  // Work for the back part
  typedef enum logic [1:0] {
    CMD_NOTE  = 2'd0,  // report the sequence field only
    CMD_WRITE = 2'd1,  // write the slot, then report the sequence field
    CMD_READ  = 2'd2   // read the slot and report it
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [MAX_SLOT_W-1:0] slot;
    entry_t                entry;
    logic [31:0]           seq;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

[src/ctr_front.sv]
// Front part: canonical form, repeat detection, ring pointers and read addressing.
module ctr_front import ctr_pkg::*; #(
  parameter int RING_SLOTS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     accept,
  input  in_item_t in_item,
  output cmd_t     cmd
);

  localparam int AW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int SW = ((AW > 6) ? AW : 6) + 1;
  localparam logic [31:0]   SLOTS32 = 32'(RING_SLOTS);
  localparam logic [SW-1:0] SLOTS_SW = SW'(RING_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_SLOTS - 1);

  logic          rec_en_r;
  logic [31:0]   taken_r, taken_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] newest_slot_r, newest_slot_nxt;
  entry_t        newest_r, newest_nxt;

  entry_t        cand;
  logic          is_record;
  logic          same;
  logic          full;
  logic [31:0]   held;
  logic          hit;
  logic [31:0]   rd_seq;
  logic [SW-1:0] rd_sum;
  logic [SW-1:0] rd_wrap;
  logic [SW-1:0] idx_sw;
  logic [AW-1:0] rd_slot;
  logic [AW-1:0] cmd_slot;

  // Canonical form of the incoming record
  always_comb begin
    cand             = '0;
    cand.fsm_state   = in_item.fsm_state;
    cand.event_code  = in_item.event_code;
    cand.detail_code = in_item.detail_code;
    cand.sub_a       = in_item.sub_a;
    cand.sub_b       = in_item.sub_b;
    cand.rc          = in_item.return_code;
    cand.aux         = in_item.aux_value;
    cand.first_time  = in_item.time_ms;
    cand.last_time   = in_item.time_ms;
    cand.repeats     = '0;
    case (in_item.opcode)
      OP_DISPATCH: begin
        cand.kind        = KIND_DISPATCH;
        cand.detail_code = (in_item.detail_code != 8'd0) ? 8'd1 : 8'd0;
        cand.rc          = '0;
      end
      OP_ARRIVAL: begin
        cand.kind  = KIND_ARRIVAL;
        cand.sub_a = '0;
        cand.sub_b = '0;
      end
      OP_EMIT: begin
        cand.kind       = KIND_EMIT;
        cand.event_code = NO_EVENT_CODE;
      end
      default: begin
        cand.kind = KIND_NONE;
      end
    endcase
  end

  assign is_record = (in_item.opcode != OP_READ);

  assign same = (taken_r != 32'd0)
             && (newest_r.kind == cand.kind)
             && (newest_r.fsm_state == cand.fsm_state)
             && (newest_r.event_code == cand.event_code)
             && (newest_r.detail_code == cand.detail_code)
             && (newest_r.sub_a == cand.sub_a)
             && (newest_r.sub_b == cand.sub_b)
             && (newest_r.rc == cand.rc)
             && (newest_r.aux == cand.aux);

  // Read addressing: oldest held slot is the write pointer once the ring is full
  assign full    = (taken_r >= SLOTS32);
  assign held    = full ? SLOTS32 : taken_r;
  assign hit     = ({26'd0, in_item.read_index} < held);
  assign rd_seq  = taken_r - held + {26'd0, in_item.read_index};
  assign idx_sw  = SW'(in_item.read_index);
  assign rd_sum  = SW'(wr_ptr_r) + idx_sw;
  assign rd_wrap = (rd_sum >= SLOTS_SW) ? (rd_sum - SLOTS_SW) : rd_sum;
  assign rd_slot = full ? rd_wrap[AW-1:0] : idx_sw[AW-1:0];

  always_comb begin
    taken_nxt       = taken_r;
    wr_ptr_nxt      = wr_ptr_r;
    newest_slot_nxt = newest_slot_r;
    newest_nxt      = newest_r;
    cmd_slot        = rd_slot;
    cmd.op          = CMD_NOTE;
    cmd.entry       = newest_r;
    cmd.seq         = taken_r;
    if (!is_record) begin
      if (hit) begin
        cmd.op  = CMD_READ;
        cmd.seq = rd_seq;
      end
    end else if (rec_en_r) begin
      cmd.op = CMD_WRITE;
      if (same) begin
        // Fold the repeat into the newest slot
        newest_nxt.repeats   = newest_r.repeats + 32'd1;
        newest_nxt.last_time = in_item.time_ms;
        cmd_slot             = newest_slot_r;
      end else begin
        // Take the next slot, overwriting the oldest once full
        newest_nxt      = cand;
        newest_slot_nxt = wr_ptr_r;
        wr_ptr_nxt      = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
        taken_nxt       = taken_r + 32'd1;
        cmd_slot        = wr_ptr_r;
      end
      cmd.entry = newest_nxt;
      cmd.seq   = taken_nxt;
    end
    cmd.slot = MAX_SLOT_W'(cmd_slot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_en_r      <= 1'b0;
      taken_r       <= '0;
      wr_ptr_r      <= '0;
      newest_slot_r <= '0;
    end else begin
      if (cfg_we) begin
        rec_en_r <= cfg_wdata;
      end
      if (accept) begin
        taken_r       <= taken_nxt;
        wr_ptr_r      <= wr_ptr_nxt;
        newest_slot_r <= newest_slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      newest_r <= newest_nxt;
    end
  end

endmodule

[src/ctr_cmd_q.sv]
// Short command queue between the front and back parts.
module ctr_cmd_q import ctr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head_cmd,
  output q_status_t status
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

  cmd_t          buf_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == DEPTH_C);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = buf_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/ctr_back.sv]
// Back part: ring memory, registered read and result register.
module ctr_back import ctr_pkg::*; #(
  parameter int RING_SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop,
  input  cmd_t      cmd,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  entry_t        slot_mem_r [RING_SLOTS];
  entry_t        rd_data_r;
  logic          s1_valid_r;
  cmd_op_t       s1_op_r;
  logic [31:0]   s1_seq_r;
  logic          out_valid_r;
  out_item_t     out_item_r, out_item_nxt;
  logic [AW-1:0] slot;

  assign slot = cmd.slot[AW-1:0];

  // Ring storage: one write or one read per cycle, commands come in order
  always_ff @(posedge clk) begin
    if (pop && (cmd.op == CMD_WRITE)) begin
      slot_mem_r[slot] <= cmd.entry;
    end
    if (pop && (cmd.op == CMD_READ)) begin
      rd_data_r <= slot_mem_r[slot];
    end
  end

  always_comb begin
    out_item_nxt              = '0;
    out_item_nxt.sequence_res = s1_seq_r;
    if (s1_op_r == CMD_READ) begin
      out_item_nxt.entry_kind   = rd_data_r.kind;
      out_item_nxt.entry_state  = rd_data_r.fsm_state;
      out_item_nxt.entry_event  = rd_data_r.event_code;
      out_item_nxt.entry_detail = rd_data_r.detail_code;
      out_item_nxt.entry_sub_a  = rd_data_r.sub_a;
      out_item_nxt.entry_sub_b  = rd_data_r.sub_b;
      out_item_nxt.entry_rc     = rd_data_r.rc;
      out_item_nxt.entry_aux    = rd_data_r.aux;
      out_item_nxt.first_time   = rd_data_r.first_time;
      out_item_nxt.last_time    = rd_data_r.last_time;
      out_item_nxt.repeat_count = rd_data_r.repeats;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= pop;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op_r  <= cmd.op;
      s1_seq_r <= cmd.seq;
    end
    if (s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[src/coalescing_trace_ring.sv]
// Top level of the coalescing trace ring.
//
// Event trace ring that merges back-to-back repeats. Pulse start with an item
// while busy is low; the item is taken at that edge. Record items (dispatch,
// arrival, emit) are put in canonical form and compared with the newest
// stored record, which the front keeps in registers; a match bumps that
// record's repeat count and last time, anything else takes the next of
// RING_SLOTS slots and overwrites the oldest once the ring is full. Read items
// return the read_index-th oldest held record. Every item yields exactly one
// result: out_valid is high for one cycle with out_item, and the receiver
// cannot hold it off. One item can be taken every cycle; the back drains the
// command queue every cycle, so busy rises only if that queue fills. The
// throughput is set by the single port of the ring memory, which does one
// write or one read per item, and the latency by the queue, the registered
// memory read and the output register. Results come out in the order the
// items were taken. No clearing pass runs after reset: slots are never read
// before they are written. Write record_enable through cfg_we/cfg_wdata only
// while no item is in flight; it resets to 0, and reads work whether
// recording is on or not.
module coalescing_trace_ring import ctr_pkg::*; #(
  parameter int RING_SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic      accept;
  cmd_t      front_cmd;
  cmd_t      head_cmd;
  q_status_t q_status;
  logic      pop;

  // Take an item whenever the queue has room
  assign busy   = q_status.full;
  assign accept = start && !busy;
  // Drain the queue every cycle it holds work
  assign pop    = !q_status.empty;

  ctr_front #(
    .RING_SLOTS(RING_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .in_item  (in_item),
    .cmd      (front_cmd)
  );

  ctr_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .push_cmd(front_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .status  (q_status)
  );

  ctr_back #(
    .RING_SLOTS(RING_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (pop),
    .cmd      (head_cmd),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

[src/ctr_checker.sv]
// Port-level checks for the coalescing trace ring, bound to the top level.
module ctr_checker import ctr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // Every taken item gives a result
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("taken item gave no result");

  // No result without an earlier taken item
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 3))
    else $error("result without a taken item");

  // Record items report no entry
  a_record_reports_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && (in_item.opcode != OP_READ), 3))
      |-> (out_item.entry_kind == KIND_NONE))
    else $error("record item reported an entry");

  // A result without an entry carries only the sequence field
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.entry_kind == KIND_NONE))
      |-> ((out_item.first_time == 32'd0) && (out_item.last_time == 32'd0)
           && (out_item.repeat_count == 32'd0) && (out_item.entry_aux == 32'd0)
           && (out_item.entry_rc == 32'sd0) && (out_item.entry_state == 8'd0)))
    else $error("empty result carries stale fields");

endmodule

bind coalescing_trace_ring ctr_checker u_ctr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);
